// ===== hw/rtl/ogf_pkg.sv =====
// ogf_pkg: shared types and constants for the occupancy grid fusion block
// used by ogf_regs, ogf_ctrl, ogf_dpath and occupancy_grid_fusion_top; no dependencies

package ogf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // global grid size in cells
  localparam int GRID_COLS = 1024;
  localparam int GRID_ROWS = 512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COS_YAW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_WEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_VALUE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_VALID    = 3'd7;

  // unknown occupancy, the value every grid cell holds after reset
  localparam logic [7:0] RESET_CELL = 8'd50;

  typedef struct packed {
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic        [8:0]  local_size;
    logic        [8:0]  keep_weight;
    logic signed [7:0]  unknown_value;
    logic               pose_valid;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROT_A,
    ST_ROT_B,
    ST_PLACE,
    ST_ADDR,
    ST_FETCH,
    ST_BLEND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic rot_a;
    logic rot_b;
    logic place;
    logic addr;
    logic fetch;
    logic blend;
    logic fin;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic fuse_ok;
    logic in_map;
    logic known;
  } stat_t;

endpackage

// ===== hw/rtl/ogf_regs.sv =====
// ogf_regs: configuration register file of the grid fusion block
// depends on ogf_pkg

module ogf_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ogf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ogf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ogf_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_yaw       <= 16'sd16384;
      cfg.sin_yaw       <= 16'sd0;
      cfg.pos_x         <= 18'sd0;
      cfg.pos_y         <= 18'sd0;
      cfg.local_size    <= 9'd0;
      cfg.keep_weight   <= 9'd243;
      cfg.unknown_value <= 8'sd50;
      cfg.pose_valid    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ogf_pkg::REG_COS_YAW:       cfg.cos_yaw       <= cfg_data[15:0];
        ogf_pkg::REG_SIN_YAW:       cfg.sin_yaw       <= cfg_data[15:0];
        ogf_pkg::REG_POS_X:         cfg.pos_x         <= cfg_data[17:0];
        ogf_pkg::REG_POS_Y:         cfg.pos_y         <= cfg_data[17:0];
        ogf_pkg::REG_LOCAL_SIZE:    cfg.local_size    <= cfg_data[8:0];
        ogf_pkg::REG_KEEP_WEIGHT:   cfg.keep_weight   <= cfg_data[8:0];
        ogf_pkg::REG_UNKNOWN_VALUE: cfg.unknown_value <= cfg_data[7:0];
        ogf_pkg::REG_POSE_VALID:    cfg.pose_valid    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ogf_ctrl.sv =====
// ogf_ctrl: sequencing state machine of the grid fusion block
// depends on ogf_pkg; drives ogf_dpath through cmd_t and reads stat_t

module ogf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ogf_pkg::stat_t      stat,
  output ogf_pkg::cmd_t       cmd,
  output logic                busy
);

  ogf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ogf_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = ogf_pkg::ST_IDLE;
      end
      ogf_pkg::ST_IDLE: begin
        if (start) state_next = ogf_pkg::ST_ROT_A;
      end
      ogf_pkg::ST_ROT_A: begin
        if (stat.is_read)      state_next = ogf_pkg::ST_PLACE;
        else if (stat.fuse_ok) state_next = ogf_pkg::ST_ROT_B;
        else                   state_next = ogf_pkg::ST_FIN;
      end
      ogf_pkg::ST_ROT_B: state_next = ogf_pkg::ST_PLACE;
      ogf_pkg::ST_PLACE: state_next = ogf_pkg::ST_ADDR;
      ogf_pkg::ST_ADDR: begin
        if (stat.in_map && (stat.is_read || stat.known)) state_next = ogf_pkg::ST_FETCH;
        else                                             state_next = ogf_pkg::ST_FIN;
      end
      ogf_pkg::ST_FETCH: begin
        if (stat.is_read) state_next = ogf_pkg::ST_FIN;
        else              state_next = ogf_pkg::ST_BLEND;
      end
      ogf_pkg::ST_BLEND: state_next = ogf_pkg::ST_FIN;
      ogf_pkg::ST_FIN:   state_next = ogf_pkg::ST_IDLE;
      default:           state_next = ogf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == ogf_pkg::ST_CLEAR);
    cmd.capture = (state == ogf_pkg::ST_IDLE) && start;
    cmd.rot_a   = (state == ogf_pkg::ST_ROT_A);
    cmd.rot_b   = (state == ogf_pkg::ST_ROT_B);
    cmd.place   = (state == ogf_pkg::ST_PLACE);
    cmd.addr    = (state == ogf_pkg::ST_ADDR);
    cmd.fetch   = (state == ogf_pkg::ST_FETCH);
    cmd.blend   = (state == ogf_pkg::ST_BLEND);
    cmd.fin     = (state == ogf_pkg::ST_FIN);
    cmd.write   = (state == ogf_pkg::ST_FIN) && !stat.is_read && stat.fuse_ok &&
                  stat.in_map && stat.known;
    busy        = (state != ogf_pkg::ST_IDLE);
  end

endmodule

// ===== hw/rtl/ogf_dpath.sv =====
// ogf_dpath: datapath of the grid fusion block: rotation, placement, grid memory, blend
// depends on ogf_pkg; commanded by ogf_ctrl

module ogf_dpath (
  input  logic                clk,
  input  logic                rst,
  input  ogf_pkg::cmd_t       cmd,
  input  ogf_pkg::cfg_t       cfg,
  input  logic                req_type,
  input  logic [7:0]          local_row,
  input  logic [7:0]          local_col,
  input  logic signed [7:0]   cell_value,
  input  logic [9:0]          read_x,
  input  logic [8:0]          read_y,
  output ogf_pkg::stat_t      stat,
  output logic                done,
  output logic signed [7:0]   read_value,
  output logic                cell_written,
  output logic                out_of_map
);

  localparam int COLS  = ogf_pkg::GRID_COLS;
  localparam int ROWS  = ogf_pkg::GRID_ROWS;
  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XA    = $clog2(COLS);
  localparam int YA    = $clog2(ROWS);
  localparam int MAXD  = (COLS > ROWS) ? COLS : ROWS;
  localparam int HB    = $clog2(MAXD) + 1;
  localparam int CW    = ((HB > 13) ? HB : 13) + 1;
  localparam int NW    = CW + 9;
  localparam int QW    = NW - 8;
  localparam logic [AW-1:0] MW_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

  logic [7:0] mem [DEPTH];

  // request word
  logic              req_q;
  logic [7:0]        row_q, col_q;
  logic signed [7:0] val_q;
  logic [9:0]        rdx_q;
  logic [8:0]        rdy_q;

  logic [AW-1:0]     clr_addr;
  logic signed [25:0] p0, p1, p2, p3;
  logic [XA-1:0]     x_q;
  logic [YA-1:0]     y_q;
  logic              in_map_q;
  logic [AW-1:0]     addr_q;
  logic [7:0]        rdata;
  logic signed [17:0] prod_q;

  logic [7:0]        half;
  logic signed [9:0] di, dj;
  logic signed [26:0] sx, sy, sxa, sya;
  logic signed [12:0] rot_x, rot_y;
  logic signed [CW-1:0] cx, cy;
  logic signed [NW-1:0] nx, ny, nxa, nya;
  logic signed [QW-1:0] qx, qy;
  logic [CW-1:0]     rx_e, ry_e;
  logic              fuse_in_map, read_in_map, local_ok;
  logic [8:0]        w_eff, w_new;
  logic signed [17:0] blend_sum;
  logic [7:0]        new_val;

  // offsets from the local grid center
  assign half = cfg.local_size[8:1];
  assign di   = $signed({2'b00, row_q} - {2'b00, half});
  assign dj   = $signed({2'b00, col_q} - {2'b00, half});

  // rotated offsets, truncated toward zero in Q1.14
  assign sx    = 27'(p0) - 27'(p1);
  assign sy    = 27'(p2) + 27'(p3);
  assign sxa   = sx + (sx[26] ? 27'sd16383 : 27'sd0);
  assign sya   = sy + (sy[26] ? 27'sd16383 : 27'sd0);
  assign rot_x = sxa[26:14];
  assign rot_y = sya[26:14];

  // map center plus pose in Q.8, truncated toward zero
  assign cx  = CW'(COLS / 2) + CW'(rot_x);
  assign cy  = CW'(ROWS / 2) + CW'(rot_y);
  assign nx  = (NW'(cx) <<< 8) + NW'(cfg.pos_x);
  assign ny  = (NW'(cy) <<< 8) + NW'(cfg.pos_y);
  assign nxa = nx + (nx[NW-1] ? NW'(255) : NW'(0));
  assign nya = ny + (ny[NW-1] ? NW'(255) : NW'(0));
  assign qx  = nxa[NW-1:8];
  assign qy  = nya[NW-1:8];

  assign fuse_in_map = !qx[QW-1] && (qx[QW-2:0] < (QW-1)'(COLS)) &&
                       !qy[QW-1] && (qy[QW-2:0] < (QW-1)'(ROWS));

  assign rx_e        = CW'(rdx_q);
  assign ry_e        = CW'(rdy_q);
  assign read_in_map = (rx_e < CW'(COLS)) && (ry_e < CW'(ROWS));

  assign local_ok = ({1'b0, row_q} < cfg.local_size) && ({1'b0, col_q} < cfg.local_size) &&
                    (CW'(row_q) < CW'(ROWS)) && (CW'(col_q) < CW'(COLS));

  // blend weights, anything above 256 acts as 256
  assign w_eff     = (cfg.keep_weight > 9'd256) ? 9'd256 : cfg.keep_weight;
  assign w_new     = 9'd256 - w_eff;
  assign blend_sum = prod_q + (prod_q[17] ? 18'sd255 : 18'sd0);
  assign new_val   = blend_sum[15:8];

  always_comb begin
    stat.clr_last = (clr_addr == LAST_ADR);
    stat.is_read  = req_q;
    stat.fuse_ok  = cfg.pose_valid && local_ok;
    stat.in_map   = in_map_q;
    stat.known    = (val_q != cfg.unknown_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      row_q <= local_row;
      col_q <= local_col;
      val_q <= cell_value;
      rdx_q <= read_x;
      rdy_q <= read_y;
    end
    if (cmd.rot_a) begin
      p0 <= di * cfg.cos_yaw;
      p1 <= dj * cfg.sin_yaw;
    end
    if (cmd.rot_b) begin
      p2 <= di * cfg.sin_yaw;
      p3 <= dj * cfg.cos_yaw;
    end
    if (cmd.place) begin
      if (req_q) begin
        x_q      <= rx_e[XA-1:0];
        y_q      <= ry_e[YA-1:0];
        in_map_q <= read_in_map;
      end else begin
        x_q      <= qx[XA-1:0];
        y_q      <= qy[YA-1:0];
        in_map_q <= fuse_in_map;
      end
    end
    if (cmd.addr) addr_q <= AW'(y_q) * MW_A + AW'(x_q);
    if (cmd.blend) begin
      prod_q <= $signed(rdata) * $signed({1'b0, w_eff}) +
                val_q * $signed({1'b0, w_new});
    end
    if (cmd.fin) begin
      read_value   <= (req_q && in_map_q) ? rdata : 8'd0;
      cell_written <= cmd.write;
      out_of_map   <= (req_q || stat.fuse_ok) && !in_map_q;
    end
  end

  // grid store: one write port shared by the clearing pass and the blend
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= ogf_pkg::RESET_CELL;
    end else if (cmd.write) begin
      mem[addr_q] <= new_val;
    end
    if (cmd.fetch) rdata <= mem[addr_q];
  end

endmodule

// ===== hw/rtl/occupancy_grid_fusion_top.sv =====
// occupancy_grid_fusion_top: top level of the occupancy grid fusion block
// depends on ogf_pkg, ogf_regs, ogf_ctrl and ogf_dpath

// Fuses local occupancy cells into a global grid of GRID_ROWS x GRID_COLS signed
// bytes (512 x 1024, fixed in ogf_pkg) held in an on-chip memory. A request word is
// taken at a clock edge with start high and busy low. A fuse request (req_type 0)
// rotates the local cell offset by the configured cosine and sine, places it around
// the map center plus the pose, and blends the local value into that grid cell; a
// read request (req_type 1) returns a stored cell. Every request gives exactly one
// result word, shown for one cycle with done high; the receiver cannot stall it, so
// it must take the word in that cycle.
// After reset the block clears the grid to 50, one cell a cycle, with busy high
// through that pass; config writes are taken during that pass. After that, a fuse
// that is skipped (no pose or cell outside the local grid) goes from the first
// rotation step straight to the result. A fuse otherwise runs both rotation multiply
// steps, a read skips the second; both then run placement and the address multiply.
// A fuse with its target off the map or an unknown value, or a read off the map,
// then ends; a read in the map adds the grid memory read, and a full fuse the read,
// blend and write-back. Busy drops with done, so a new request can be taken in the
// cycle done is shown. Config is written over its own valid/ready channel, always
// ready, and must only change while the block is idle.

module occupancy_grid_fusion_top (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [7:0]                      local_row,
  input  logic [7:0]                      local_col,
  input  logic signed [7:0]               cell_value,
  input  logic [9:0]                      read_x,
  input  logic [8:0]                      read_y,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ogf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ogf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // result side
  output logic                            done,
  output logic signed [7:0]               read_value,
  output logic                            cell_written,
  output logic                            out_of_map
);

  ogf_pkg::cfg_t  cfg;
  ogf_pkg::cmd_t  cmd;
  ogf_pkg::stat_t stat;

  // register file, written by index
  ogf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: clearing pass, then one request at a time
  ogf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // rotation, placement, grid memory and blend
  ogf_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .req_type     (req_type),
    .local_row    (local_row),
    .local_col    (local_col),
    .cell_value   (cell_value),
    .read_x       (read_x),
    .read_y       (read_y),
    .stat         (stat),
    .done         (done),
    .read_value   (read_value),
    .cell_written (cell_written),
    .out_of_map   (out_of_map)
  );

  // an accepted word always puts the sequencer to work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // each result word is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // a written cell is in the map and returns no read data
  a_write_flags: assert property (@(posedge clk) disable iff (rst)
    done && cell_written |-> !out_of_map && (read_value == 8'sd0))
    else $error("written cell reported with inconsistent flags");

  // no result word while the sequencer is working
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

endmodule

// ===== tb/occupancy_grid_fusion_top_tb.sv =====
// occupancy_grid_fusion_top_tb: self-checking testbench for the occupancy grid fusion block
// depends on ogf_pkg and occupancy_grid_fusion_top; keeps its own copy of the global grid

module occupancy_grid_fusion_top_tb;
  import ogf_pkg::*;

  localparam int MAP_W = GRID_COLS;
  localparam int MAP_H = GRID_ROWS;
  localparam int RANDOM_WORDS = 600;
  localparam int PHASE_WORDS = 60;
  localparam int HIT_DEPTH = 32;
  // the grid clear alone is 2M time units; the request traffic adds well under 0.2M
  localparam int TIMEOUT_TU = 8000000;

  // one result word as the block shows it
  typedef struct {
    logic signed [7:0] read_value;
    logic              cell_written;
    logic              out_of_map;
  } grid_word_t;

  // mirrors the global grid and the register file, and queues the words the block owes us
  class fusion_scoreboard;
    byte          grid [MAP_W*MAP_H];
    cfg_t         settings;
    grid_word_t   owed_words [$];
    int unsigned  hit_cells [$];
    int           errors;

    function new();
      foreach (grid[k]) grid[k] = byte'(RESET_CELL);
      settings = '{cos_yaw: 16384, sin_yaw: 0, pos_x: 0, pos_y: 0, local_size: 0,
                   keep_weight: 243, unknown_value: 50, pose_valid: 0};
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COS_YAW:       settings.cos_yaw       = data[15:0];
        REG_SIN_YAW:       settings.sin_yaw       = data[15:0];
        REG_POS_X:         settings.pos_x         = data[17:0];
        REG_POS_Y:         settings.pos_y         = data[17:0];
        REG_LOCAL_SIZE:    settings.local_size    = data[8:0];
        REG_KEEP_WEIGHT:   settings.keep_weight   = data[8:0];
        REG_UNKNOWN_VALUE: settings.unknown_value = data[7:0];
        REG_POSE_VALID:    settings.pose_valid    = data[0];
        default: ;
      endcase
    endfunction

    // predicts the word for one accepted request; returns 1 unless the block ignores it
    function bit note_request(logic rq, logic [7:0] row, logic [7:0] col,
                              logic signed [7:0] val, logic [9:0] rx, logic [8:0] ry);
      grid_word_t w;
      longint lsz, half, di, dj, c, s, px, py, rot_x, rot_y, x, y, g, wt;
      int unsigned a;
      bit used;
      w = '{read_value: 0, cell_written: 0, out_of_map: 0};
      used = 0;
      if (rq) begin
        used = 1;
        if (rx < MAP_W && ry < MAP_H) w.read_value = grid[ry * MAP_W + rx];
        else w.out_of_map = 1'b1;
      end else if (settings.pose_valid) begin
        lsz = settings.local_size;
        if (longint'(row) < lsz && longint'(col) < lsz) begin
          used = 1;
          half = lsz / 2;
          di = longint'(row) - half;
          dj = longint'(col) - half;
          c = $signed(settings.cos_yaw);
          s = $signed(settings.sin_yaw);
          px = $signed(settings.pos_x);
          py = $signed(settings.pos_y);
          // rotation and placement both truncate toward zero
          rot_x = (di * c - dj * s) / 16384;
          rot_y = (di * s + dj * c) / 16384;
          x = ((MAP_W / 2 + rot_x) * 256 + px) / 256;
          y = ((MAP_H / 2 + rot_y) * 256 + py) / 256;
          if (x < 0 || x >= MAP_W || y < 0 || y >= MAP_H) begin
            w.out_of_map = 1'b1;
          end else begin
            a = int'(y * MAP_W + x);
            hit_cells = {hit_cells, a};
            if (hit_cells.size() > HIT_DEPTH) void'(hit_cells.pop_front());
            if (val != settings.unknown_value) begin
              wt = (settings.keep_weight > 256) ? 256 : settings.keep_weight;
              g = grid[a];
              grid[a] = byte'((g * wt + longint'(val) * (256 - wt)) / 256);
              w.cell_written = 1'b1;
            end
          end
        end
      end
      owed_words = {owed_words, w};
      return used;
    endfunction

    function void check_word(logic signed [7:0] rv, logic wr, logic oom);
      grid_word_t w;
      if (owed_words.size() == 0) begin
        errors++;
        $error("result word with no request pending");
        return;
      end
      w = owed_words.pop_front();
      if (rv !== w.read_value) begin
        errors++;
        $error("read_value: expected %0d, got %0d", w.read_value, rv);
      end
      if (wr !== w.cell_written) begin
        errors++;
        $error("cell_written: expected %0d, got %0d", w.cell_written, wr);
      end
      if (oom !== w.out_of_map) begin
        errors++;
        $error("out_of_map: expected %0d, got %0d", w.out_of_map, oom);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    req_type = 1'b0;
  logic [7:0]              local_row = '0;
  logic [7:0]              local_col = '0;
  logic signed [7:0]       cell_value = '0;
  logic [9:0]              read_x = '0;
  logic [8:0]              read_y = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    done;
  logic signed [7:0]       read_value;
  logic                    cell_written;
  logic                    out_of_map;

  fusion_scoreboard sb;
  bit idle_gaps = 1'b1;
  int counted = 0;

  occupancy_grid_fusion_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .local_row   (local_row),
    .local_col   (local_col),
    .cell_value  (cell_value),
    .read_x      (read_x),
    .read_y      (read_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .read_value  (read_value),
    .cell_written(cell_written),
    .out_of_map  (out_of_map)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // done is never stalled, so every strobed word is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) sb.check_word(read_value, cell_written, out_of_map);
  end

  // one request word: start stays up until an edge sees busy low; start is only
  // lowered when a gap follows, so back-to-back words keep it high
  task automatic send_request(input logic rq, input logic [7:0] row, input logic [7:0] col,
                              input logic signed [7:0] val, input logic [9:0] rx,
                              input logic [8:0] ry);
    int gap;
    int roll;
    start      <= 1'b1;
    req_type   <= rq;
    local_row  <= row;
    local_col  <= col;
    cell_value <= val;
    read_x     <= rx;
    read_y     <= ry;
    do @(posedge clk); while (busy);
    void'(sb.note_request(rq, row, col, val, rx, ry));
    counted++;
    // mostly no gap or a short one, now and then a long one
    roll = $urandom_range(0, 99);
    if (!idle_gaps || roll < 50) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // cfg_valid is left high between writes of one batch and dropped by write_settings
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic write_settings(input cfg_t cs);
    write_reg(REG_COS_YAW,       CFG_DATA_W'(cs.cos_yaw));
    write_reg(REG_SIN_YAW,       CFG_DATA_W'(cs.sin_yaw));
    write_reg(REG_POS_X,         CFG_DATA_W'(cs.pos_x));
    write_reg(REG_POS_Y,         CFG_DATA_W'(cs.pos_y));
    write_reg(REG_LOCAL_SIZE,    CFG_DATA_W'(cs.local_size));
    write_reg(REG_KEEP_WEIGHT,   CFG_DATA_W'(cs.keep_weight));
    write_reg(REG_UNKNOWN_VALUE, CFG_DATA_W'(cs.unknown_value));
    write_reg(REG_POSE_VALID,    CFG_DATA_W'(cs.pose_valid));
    cfg_valid <= 1'b0;
  endtask

  // every request owes exactly one word, so an empty queue means the block is idle
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic cfg_t random_setting();
    cfg_t cs;
    // yaw terms: mostly anything in range, sometimes an axis-aligned extreme
    if ($urandom_range(0, 9) < 7) begin
      cs.cos_yaw = 16'($urandom_range(0, 32768) - 16384);
      cs.sin_yaw = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      case ($urandom_range(0, 3))
        0: begin cs.cos_yaw = 16384;  cs.sin_yaw = 0;      end
        1: begin cs.cos_yaw = -16384; cs.sin_yaw = 0;      end
        2: begin cs.cos_yaw = 0;      cs.sin_yaw = 16384;  end
        default: begin cs.cos_yaw = 0; cs.sin_yaw = -16384; end
      endcase
    end
    // pose near the map center most of the time so targets land in the grid
    if ($urandom_range(0, 9) < 8) begin
      cs.pos_x = 18'($urandom_range(0, 153600) - 76800);
      cs.pos_y = 18'($urandom_range(0, 76800) - 38400);
    end else begin
      cs.pos_x = 18'($urandom);
      cs.pos_y = 18'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       cs.local_size = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
      1, 2:    cs.local_size = 9'($urandom_range(65, 256));
      default: cs.local_size = 9'($urandom_range(1, 64));
    endcase
    cs.keep_weight   = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(0, 256))
                                                   : 9'($urandom_range(257, 511));
    cs.unknown_value = 8'($urandom);
    cs.pose_valid    = ($urandom_range(0, 9) != 0);
    return cs;
  endfunction

  initial begin
    cfg_t cur;
    int phase_goal;
    int span;
    int unsigned a;
    logic [7:0] row, col;
    logic signed [7:0] val;
    logic [9:0] rx;
    logic [8:0] ry;

    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // registers go in while the grid clear runs; no pose yet
    write_settings('{cos_yaw: 16384, sin_yaw: 0, pos_x: 0, pos_y: 0, local_size: 16,
                     keep_weight: 243, unknown_value: 50, pose_valid: 0});

    // fusing without a pose does nothing; the grid corners read back as unknown
    send_request(1'b0, 8'd0, 8'd0, 8'sd100, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd0, 9'd0);
    send_request(1'b1, 8'd255, 8'd255, -8'sd1, 10'd1023, 9'd511);

    // identity rotation around the map center, 16x16 local grid
    drain();
    write_settings('{cos_yaw: 16384, sin_yaw: 0, pos_x: 0, pos_y: 0, local_size: 16,
                     keep_weight: 243, unknown_value: 50, pose_valid: 1});
    send_request(1'b0, 8'd0, 8'd0, 8'sd100, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd504, 9'd248);
    send_request(1'b0, 8'd15, 8'd15, -8'sd128, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd519, 9'd263);
    // row just past the local grid is ignored
    send_request(1'b0, 8'd16, 8'd0, 8'sd10, 10'd0, 9'd0);
    // unknown value: target computed, nothing written
    send_request(1'b0, 8'd3, 8'd3, 8'sd50, 10'd0, 9'd0);
    // blend onto an already fused cell
    send_request(1'b0, 8'd0, 8'd0, 8'sd127, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd504, 9'd248);

    // extreme yaw and pose, full local grid, zero keep weight (plain overwrite)
    drain();
    write_settings('{cos_yaw: -16384, sin_yaw: 16384, pos_x: -131072, pos_y: 131071,
                     local_size: 256, keep_weight: 0, unknown_value: -128, pose_valid: 1});
    send_request(1'b0, 8'd0, 8'd0, -8'sd128, 10'd0, 9'd0);
    send_request(1'b0, 8'd255, 8'd255, 8'sd127, 10'd0, 9'd0);
    send_request(1'b0, 8'd255, 8'd0, -8'sd127, 10'd0, 9'd0);
    send_request(1'b0, 8'd0, 8'd255, 8'sd1, 10'd0, 9'd0);

    // opposite extremes, local size beyond the row range, weight clamped to 256
    drain();
    write_settings('{cos_yaw: 0, sin_yaw: -16384, pos_x: 131071, pos_y: -131072,
                     local_size: 511, keep_weight: 511, unknown_value: 127, pose_valid: 1});
    send_request(1'b0, 8'd255, 8'd0, 8'sd127, 10'd0, 9'd0);
    send_request(1'b0, 8'd0, 8'd255, -8'sd128, 10'd0, 9'd0);
    send_request(1'b0, 8'd200, 8'd100, 8'sd5, 10'd0, 9'd0);
    a = sb.hit_cells[sb.hit_cells.size() - 1];
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'(a % MAP_W), 9'(a / MAP_W));

    // empty local grid: every fuse is ignored
    drain();
    write_settings('{cos_yaw: 16384, sin_yaw: 0, pos_x: 0, pos_y: 0, local_size: 0,
                     keep_weight: 256, unknown_value: 0, pose_valid: 1});
    send_request(1'b0, 8'd0, 8'd0, 8'sd1, 10'd0, 9'd0);

    // weight just above 256 acts as full keep
    drain();
    write_settings('{cos_yaw: 16384, sin_yaw: 0, pos_x: 0, pos_y: 0, local_size: 8,
                     keep_weight: 300, unknown_value: 0, pose_valid: 1});
    send_request(1'b0, 8'd7, 8'd7, -8'sd100, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd515, 9'd259);
    send_request(1'b0, 8'd0, 8'd0, 8'sd0, 10'd0, 9'd0);
    send_request(1'b1, 8'd0, 8'd0, 8'sd0, 10'd1023, 9'd0);

    // random phases: fresh register settings, then a burst of requests each;
    // fuses mostly fall inside the local grid, reads mostly revisit fused cells
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      cur = random_setting();
      drain();
      write_settings(cur);
      idle_gaps = ($urandom_range(0, 3) != 0);
      span = (cur.local_size > 256) ? 256 : int'(cur.local_size);
      phase_goal = counted + PHASE_WORDS;
      while (counted < phase_goal) begin
        row = 8'($urandom);
        col = 8'($urandom);
        val = 8'($urandom);
        rx  = 10'($urandom);
        ry  = 9'($urandom);
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 9) < 6 && sb.hit_cells.size() != 0) begin
            a  = sb.hit_cells[$urandom_range(0, sb.hit_cells.size() - 1)];
            rx = 10'(a % MAP_W);
            ry = 9'(a / MAP_W);
          end
          send_request(1'b1, row, col, val, rx, ry);
        end else begin
          if (span != 0 && $urandom_range(0, 9) < 9) begin
            row = 8'($urandom_range(0, span - 1));
            col = 8'($urandom_range(0, span - 1));
          end
          if ($urandom_range(0, 9) < 2) val = cur.unknown_value;
          send_request(1'b0, row, col, val, rx, ry);
        end
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_TU);
    $display("Some tests failed");
    $finish;
  end

endmodule
